### rtl/dmsp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dmsp_pkg: shared types and codes for the descriptor-matched slot pool
// Field widths, operation and status codes, request and result structs.
// ----------------------------------------------------------------------------
package dmsp_pkg;

  // Field widths
  localparam int OP_W     = 2;
  localparam int IDX_W    = 6;
  localparam int DIM_W    = 15;
  localparam int FMT_W    = 8;
  localparam int USE_W    = 32;
  localparam int ASP_W    = 12;
  localparam int ACC_W    = 4;
  localparam int STAT_W   = 2;
  localparam int CNT_W    = 7;
  localparam int DESC_W   = 2 * DIM_W + FMT_W + USE_W + ASP_W;

  localparam int SLOTS_DEFAULT = 64;

  // Operation codes
  localparam logic [OP_W-1:0] OP_ALLOC = 2'd0;
  localparam logic [OP_W-1:0] OP_FREE  = 2'd1;
  localparam logic [OP_W-1:0] OP_SET   = 2'd2;
  localparam logic [OP_W-1:0] OP_QUERY = 2'd3;

  // Status codes
  localparam logic [STAT_W-1:0] STAT_OK     = 2'd0;
  localparam logic [STAT_W-1:0] STAT_REJECT = 2'd1;
  localparam logic [STAT_W-1:0] STAT_FULL   = 2'd2;
  localparam logic [STAT_W-1:0] STAT_BAD    = 2'd3;

  typedef struct packed {
    logic [OP_W-1:0]  op;
    logic [IDX_W-1:0] slot_index;
    logic [DIM_W-1:0] image_width;
    logic [DIM_W-1:0] image_height;
    logic [FMT_W-1:0] pixel_format;
    logic [USE_W-1:0] usage_flags;
    logic [ASP_W-1:0] aspect_flags;
    logic [ACC_W-1:0] new_access_state;
  } req_t;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [IDX_W-1:0]  granted_slot;
    logic              was_reused;
    logic              slot_is_allocated;
    logic [ACC_W-1:0]  slot_access_state;
    logic [CNT_W-1:0]  slots_in_use;
    logic [CNT_W-1:0]  allocated_total;
  } rsp_t;

endpackage

### rtl/dmsp_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dmsp_ram: simple dual-port RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module dmsp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### rtl/descriptor_matched_slot_pool_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// descriptor_matched_slot_pool_unit: image descriptor slot pool, LIFO free list
// Allocate, free, set-usage and query over a pool of SLOTS descriptor slots.
// ----------------------------------------------------------------------------
// Usage:
//   A request transfers at a rising edge with start high and busy low. busy
//   stays high while the request is worked on. Exactly one result follows,
//   shown on result for one cycle with done high; it cannot be held off.
// Paths (start edge to done):
//   rejected allocate or bad slot index: done in the cycle after the edge.
//   free / set usage / query: one slot-state RAM read, then done.
//   allocate, empty free list: straight to creating a new slot, or full.
//   allocate with F free entries: the scan runs one entry per cycle through
//   a free-list read, a descriptor read and the shared descriptor comparator.
//   A miss then creates a new slot; a hit with d newer entries above it
//   shifts those d entries down one per cycle. Worst case is a hit on the
//   oldest entry.
// Throughput: one request at a time; the next start is taken once busy falls.
// Reset: synchronous rst empties the free list and the pool counts; slot
//   storage is not cleared, since only created slots are ever read.
// ----------------------------------------------------------------------------
module descriptor_matched_slot_pool_unit #(
  parameter int SLOTS = dmsp_pkg::SLOTS_DEFAULT
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  output logic           busy,
  input  dmsp_pkg::req_t request,
  output logic           done,
  output dmsp_pkg::rsp_t result
);

  import dmsp_pkg::*;

  localparam int SW = $clog2(SLOTS);
  localparam int CW = $clog2(SLOTS + 1);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_EXEC  = 3'd1;
  localparam logic [2:0] S_SCAN  = 3'd2;
  localparam logic [2:0] S_SHIFT = 3'd3;
  localparam logic [2:0] S_NEW   = 3'd4;

  // Control registers
  logic [2:0]    state, state_next;
  req_t          req, req_next;
  logic [SW-1:0] cur_slot, cur_slot_next;
  logic [CW-1:0] free_length, free_length_next;
  logic [CW-1:0] created, created_next;
  logic [CW-1:0] scan_left, scan_left_next;
  logic          vb, vb_next, vc, vc_next;
  logic [SW-1:0] pos_b, pos_b_next, pos_c, pos_c_next;
  logic [SW-1:0] slot_c, slot_c_next;
  logic [CW-1:0] sh_ptr, sh_ptr_next;
  logic          wv, wv_next;
  logic [SW-1:0] wa, wa_next;
  rsp_t          rsp, rsp_next;
  logic          done_r, done_next;

  // RAM ports
  logic              desc_we;
  logic [SW-1:0]     desc_wa, desc_ra;
  logic [DESC_W-1:0] desc_wd, desc_rd, key;
  logic              acc_we;
  logic [SW-1:0]     acc_wa;
  logic [ACC_W-1:0]  acc_wd, acc_rd;
  logic              live_we;
  logic [SW-1:0]     live_wa;
  logic              live_wd, live_rd;
  logic              fs_we;
  logic [SW-1:0]     fs_wa, fs_wd, fs_ra, fs_rd;
  logic              match;

  dmsp_ram #(.WIDTH(DESC_W), .DEPTH(SLOTS)) u_desc (
    .clk(clk), .we(desc_we), .waddr(desc_wa), .wdata(desc_wd),
    .raddr(desc_ra), .rdata(desc_rd)
  );

  dmsp_ram #(.WIDTH(ACC_W), .DEPTH(SLOTS)) u_access (
    .clk(clk), .we(acc_we), .waddr(acc_wa), .wdata(acc_wd),
    .raddr(cur_slot_next), .rdata(acc_rd)
  );

  dmsp_ram #(.WIDTH(1), .DEPTH(SLOTS)) u_live (
    .clk(clk), .we(live_we), .waddr(live_wa), .wdata(live_wd),
    .raddr(cur_slot_next), .rdata(live_rd)
  );

  dmsp_ram #(.WIDTH(SW), .DEPTH(SLOTS)) u_free (
    .clk(clk), .we(fs_we), .waddr(fs_wa), .wdata(fs_wd),
    .raddr(fs_ra), .rdata(fs_rd)
  );

  // Shared comparator: stored descriptor against the request descriptor
  assign key = {req.image_width, req.image_height, req.pixel_format,
                req.usage_flags, req.aspect_flags};
  assign match = (desc_rd == key);

  // Sequencer
  always_comb begin
    logic reject;
    logic idx_ok;

    state_next       = state;
    req_next         = req;
    cur_slot_next    = cur_slot;
    free_length_next = free_length;
    created_next     = created;
    scan_left_next   = scan_left;
    vb_next          = 1'b0;
    vc_next          = 1'b0;
    pos_b_next       = pos_b;
    pos_c_next       = pos_c;
    slot_c_next      = slot_c;
    sh_ptr_next      = sh_ptr;
    wv_next          = 1'b0;
    wa_next          = wa;
    rsp_next         = '0;
    done_next        = 1'b0;

    desc_we = 1'b0;
    desc_wa = SW'(created);
    desc_wd = key;
    desc_ra = fs_rd;
    acc_we  = 1'b0;
    acc_wa  = cur_slot;
    acc_wd  = req.new_access_state;
    live_we = 1'b0;
    live_wa = cur_slot;
    live_wd = 1'b0;
    fs_we   = 1'b0;
    fs_wa   = wa;
    fs_wd   = fs_rd;
    fs_ra   = SW'(scan_left - 1'b1);

    reject = (request.image_width == '0) || (request.image_height == '0) ||
             (request.pixel_format == '0) || (request.usage_flags == '0);
    idx_ok = (int'(request.slot_index) < int'(created)) &&
             (int'(request.slot_index) < SLOTS);

    case (state)
      S_IDLE: begin
        if (start) begin
          req_next      = request;
          cur_slot_next = SW'(request.slot_index);
          if (request.op == OP_ALLOC) begin
            if (reject) begin
              rsp_next.status = STAT_REJECT;
              done_next       = 1'b1;
            end else if (free_length == '0) begin
              state_next = S_NEW;
            end else begin
              scan_left_next = free_length;
              state_next     = S_SCAN;
            end
          end else if (!idx_ok) begin
            rsp_next.status = STAT_BAD;
            done_next       = 1'b1;
          end else begin
            state_next = S_EXEC;
          end
        end
      end

      // Free, set usage, query: slot state read is now valid
      S_EXEC: begin
        state_next = S_IDLE;
        done_next  = 1'b1;
        case (req.op)
          OP_FREE: begin
            if (!live_rd || free_length >= CW'(SLOTS)) begin
              rsp_next.status = STAT_BAD;
            end else begin
              live_we          = 1'b1;
              live_wd          = 1'b0;
              fs_we            = 1'b1;
              fs_wa            = SW'(free_length);
              fs_wd            = cur_slot;
              free_length_next = free_length + 1'b1;
              rsp_next.slot_access_state = acc_rd;
            end
          end
          OP_SET: begin
            acc_we = 1'b1;
            rsp_next.slot_is_allocated = live_rd;
            rsp_next.slot_access_state = req.new_access_state;
          end
          default: begin
            rsp_next.slot_is_allocated = live_rd;
            rsp_next.slot_access_state = acc_rd;
          end
        endcase
      end

      // Free-list scan, newest first: read entry, read descriptor, compare
      S_SCAN: begin
        if (scan_left != '0) begin
          vb_next        = 1'b1;
          pos_b_next     = SW'(scan_left - 1'b1);
          scan_left_next = scan_left - 1'b1;
        end
        vc_next     = vb;
        pos_c_next  = pos_b;
        slot_c_next = fs_rd;
        if (vc && match) begin
          vb_next       = 1'b0;
          vc_next       = 1'b0;
          cur_slot_next = slot_c;
          sh_ptr_next   = CW'(pos_c) + 1'b1;
          state_next    = S_SHIFT;
        end else if (scan_left == '0 && !vb) begin
          state_next = S_NEW;
        end
      end

      // Close the gap: entry k takes entry k + 1, one per cycle
      S_SHIFT: begin
        if (wv) begin
          fs_we = 1'b1;
        end
        fs_ra = SW'(sh_ptr);
        if (sh_ptr < free_length) begin
          wv_next     = 1'b1;
          wa_next     = SW'(sh_ptr - 1'b1);
          sh_ptr_next = sh_ptr + 1'b1;
        end else if (!wv) begin
          free_length_next = free_length - 1'b1;
          live_we          = 1'b1;
          live_wd          = 1'b1;
          state_next       = S_IDLE;
          done_next        = 1'b1;
          rsp_next.granted_slot      = IDX_W'(cur_slot);
          rsp_next.was_reused        = 1'b1;
          rsp_next.slot_is_allocated = 1'b1;
          rsp_next.slot_access_state = acc_rd;
        end
      end

      // No reusable slot: create one at the end of the pool
      S_NEW: begin
        state_next = S_IDLE;
        done_next  = 1'b1;
        if (created >= CW'(SLOTS)) begin
          rsp_next.status = STAT_FULL;
        end else begin
          desc_we      = 1'b1;
          acc_we       = 1'b1;
          acc_wa       = SW'(created);
          acc_wd       = '0;
          live_we      = 1'b1;
          live_wa      = SW'(created);
          live_wd      = 1'b1;
          created_next = created + 1'b1;
          rsp_next.granted_slot      = IDX_W'(created);
          rsp_next.slot_is_allocated = 1'b1;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase

    rsp_next.slots_in_use    = CNT_W'(created_next);
    rsp_next.allocated_total = CNT_W'(created_next - free_length_next);
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      free_length <= '0;
      created     <= '0;
      scan_left   <= '0;
      vb          <= 1'b0;
      vc          <= 1'b0;
      wv          <= 1'b0;
      done_r      <= 1'b0;
    end else begin
      state       <= state_next;
      free_length <= free_length_next;
      created     <= created_next;
      scan_left   <= scan_left_next;
      vb          <= vb_next;
      vc          <= vc_next;
      wv          <= wv_next;
      done_r      <= done_next;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    req      <= req_next;
    cur_slot <= cur_slot_next;
    pos_b    <= pos_b_next;
    pos_c    <= pos_c_next;
    slot_c   <= slot_c_next;
    sh_ptr   <= sh_ptr_next;
    wa       <= wa_next;
    rsp      <= rsp_next;
  end

  assign busy   = (state != S_IDLE);
  assign done   = done_r;
  assign result = rsp;

endmodule
